// ===== src/arp_cache_responder_macros.svh =====
// assertion macros for the arp cache responder
`ifndef ARP_CACHE_RESPONDER_MACROS_SVH
`define ARP_CACHE_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF
`define ARPCR_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ARPCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ARPCR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ARPCR_ASSERT(label, expr, msg)
`define ARPCR_ASSERT_IMP(label, ante, cons, msg)
`define ARPCR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== src/arpcr_pkg.sv =====
// types and constants of the arp cache responder
package arpcr_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam logic [31:0] LocalIpRst    = 32'hC0A8_0164;
  localparam logic [47:0] LocalMacRst   = 48'h0;
  localparam logic [15:0] LifetimeRst   = 16'd300;
  localparam logic [47:0] BroadcastMac  = 48'hFFFF_FFFF_FFFF;

  localparam logic [15:0] HwEthernet    = 16'h0001;
  localparam logic [15:0] ProtoIpv4     = 16'h0800;
  localparam logic [15:0] OpRequest     = 16'h0001;
  localparam logic [1:0]  FrameOpReq    = 2'd1;
  localparam logic [1:0]  FrameOpReply  = 2'd2;

  localparam logic [1:0] ModePacket  = 2'd0;
  localparam logic [1:0] ModeResolve = 2'd1;
  localparam logic [1:0] ModeTick    = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  localparam logic [1:0] CfgLocalIp  = 2'd0;
  localparam logic [1:0] CfgLocalMac = 2'd1;
  localparam logic [1:0] CfgLifetime = 2'd2;
  localparam logic [1:0] CfgEnable   = 2'd3;

  localparam logic [2:0] StatOff     = 3'd0;
  localparam logic [2:0] StatBadType = 3'd1;
  localparam logic [2:0] StatLearned = 3'd2;
  localparam logic [2:0] StatReplied = 3'd3;
  localparam logic [2:0] StatHit     = 3'd4;
  localparam logic [2:0] StatMiss    = 3'd5;
  localparam logic [2:0] StatTick    = 3'd6;

  typedef enum logic [1:0] {
    KIND_LEARN,
    KIND_RESOLVE,
    KIND_TICK,
    KIND_NONE
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

endpackage

// ===== src/arp_cache_responder.sv =====
// arp cache responder top level: table scan sequencer, entry memories and result register
`include "arp_cache_responder_macros.svh"
// One transaction in, one result out. Packets, resolve queries and aging ticks walk the
// whole table through a single read port with one shared address compare and ttl
// decrement, one entry per cycle; a learn packet then passes through the table write
// state. A disabled packet, a bad type or an unused mode skips the scan and goes
// straight to the result. The result sits in an output register, so a new transaction
// is taken while the previous result waits.
module arp_cache_responder
  import arpcr_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [15:0] opcode_i,
  input  logic [31:0] sender_ip_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] target_ip_i,
  input  logic [31:0] query_ip_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        frame_valid_o,
  output logic [1:0]  frame_opcode_o,
  output logic [47:0] frame_dest_mac_o,
  output logic [47:0] frame_target_mac_o,
  output logic [31:0] frame_target_ip_o,
  output logic [47:0] resolved_mac_o
);

  localparam int unsigned IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam logic [CW-1:0] LastCnt = CW'(TableEntries);

  // configuration
  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;
  logic [15:0] lifetime_q;
  logic        enable_q;

  // sequencer
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_m1;
  logic          in_accept, scan_step, eval_en, wr_en, load_out;

  // current transaction
  kind_e       kind_q, in_kind;
  logic [2:0]  in_status, status_q;
  logic        req_hit_q;
  logic [31:0] key_ip_q;
  logic [47:0] key_mac_q;

  // scan results
  logic          found_q, free_q;
  logic [IW-1:0] found_idx_q, free_idx_q;
  logic [47:0]   found_mac_q;

  // table
  logic [TableEntries-1:0] valid_q;
  logic [31:0]   ip_mem  [TableEntries];
  logic [47:0]   mac_mem [TableEntries];
  logic [15:0]   ttl_mem [TableEntries];
  logic [31:0]   rd_ip_q;
  logic [47:0]   rd_mac_q;
  logic [15:0]   rd_ttl_q;
  logic [IW-1:0] rd_addr, ev_idx, wr_idx, ttl_waddr;
  logic          ev_valid, ev_hit, ttl_we, ip_we, mac_we;
  logic [15:0]   ttl_wdata;

  // result
  logic        out_valid_q;
  logic [2:0]  res_status;
  logic        res_fv;
  logic [1:0]  res_fop;
  logic [47:0] res_fdst, res_ftmac, res_rmac;
  logic [31:0] res_ftip;

  // classify the incoming transaction
  always_comb begin
    in_kind   = KIND_NONE;
    in_status = StatBadType;
    unique case (mode_i)
      ModePacket: begin
        if (!enable_q) begin
          in_status = StatOff;
        end else if (hw_type_i == HwEthernet && proto_type_i == ProtoIpv4) begin
          in_kind = KIND_LEARN;
        end
      end
      ModeResolve: in_kind = KIND_RESOLVE;
      ModeTick:    in_kind = KIND_TICK;
      ModeUnused:  in_kind = KIND_NONE;
      default:     in_kind = KIND_NONE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind == KIND_NONE) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LastCnt) begin
          state_d = (kind_q == KIND_LEARN) ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    scan_step  = 1'b0;
    eval_en    = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN: begin
        scan_step = (cnt_q != LastCnt);
        eval_en   = (cnt_q != '0);
      end
      ST_WRITE:  wr_en = 1'b1;
      ST_FINISH: load_out = !out_valid_q || out_ready_i;
      default:   in_ready_o = 1'b0;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign cnt_m1    = cnt_q - CW'(1);
  assign ev_idx    = cnt_m1[IW-1:0];
  assign rd_addr   = (cnt_q < LastCnt) ? cnt_q[IW-1:0] : '0;

  // shared compare and decrement on the entry read last cycle
  assign ev_valid = valid_q[ev_idx];
  assign ev_hit   = ev_valid && (rd_ip_q == key_ip_q);

  assign wr_idx    = found_q ? found_idx_q : free_idx_q;
  assign ip_we     = wr_en && !found_q && free_q;
  assign mac_we    = wr_en && (found_q || free_q);
  assign ttl_we    = mac_we ||
                     (eval_en && kind_q == KIND_TICK && ev_valid && rd_ttl_q != '0);
  assign ttl_waddr = wr_en ? wr_idx : ev_idx;
  assign ttl_wdata = wr_en ? lifetime_q : rd_ttl_q - 16'd1;

  always_ff @(posedge clk_i) begin
    rd_ip_q  <= ip_mem[rd_addr];
    rd_mac_q <= mac_mem[rd_addr];
    rd_ttl_q <= ttl_mem[rd_addr];
    if (ip_we) begin
      ip_mem[wr_idx] <= key_ip_q;
    end
    if (mac_we) begin
      mac_mem[wr_idx] <= key_mac_q;
    end
    if (ttl_we) begin
      ttl_mem[ttl_waddr] <= ttl_wdata;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      local_ip_q  <= LocalIpRst;
      local_mac_q <= LocalMacRst;
      lifetime_q  <= LifetimeRst;
      enable_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLocalIp:  local_ip_q  <= cfg_data_i[31:0];
          CfgLocalMac: local_mac_q <= cfg_data_i;
          CfgLifetime: lifetime_q  <= cfg_data_i[15:0];
          CfgEnable:   enable_q    <= cfg_data_i[0];
          default:     enable_q    <= enable_q;
        endcase
      end
      if (in_accept) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (scan_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (eval_en && kind_q != KIND_TICK) begin
        if (ev_hit && !found_q) begin
          found_q <= 1'b1;
        end
        if (!ev_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (eval_en && kind_q == KIND_TICK && ev_valid && rd_ttl_q == '0) begin
        valid_q[ev_idx] <= 1'b0;
      end
      if (ip_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= in_kind;
      status_q  <= in_status;
      req_hit_q <= (opcode_i == OpRequest) && (target_ip_i == local_ip_q);
      key_ip_q  <= (mode_i == ModePacket) ? sender_ip_i : query_ip_i;
      key_mac_q <= sender_mac_i;
    end
    if (eval_en && kind_q != KIND_TICK) begin
      if (ev_hit && !found_q) begin
        found_idx_q <= ev_idx;
        found_mac_q <= rd_mac_q;
      end
      if (!ev_valid && !free_q) begin
        free_idx_q <= ev_idx;
      end
    end
  end

  // result assembly
  always_comb begin
    res_status = status_q;
    res_fv     = 1'b0;
    res_fop    = '0;
    res_fdst   = '0;
    res_ftmac  = '0;
    res_ftip   = '0;
    res_rmac   = '0;
    unique case (kind_q)
      KIND_LEARN: begin
        res_status = req_hit_q ? StatReplied : StatLearned;
        if (req_hit_q) begin
          res_fv    = 1'b1;
          res_fop   = FrameOpReply;
          res_fdst  = key_mac_q;
          res_ftmac = key_mac_q;
          res_ftip  = key_ip_q;
        end
      end
      KIND_RESOLVE: begin
        if (found_q) begin
          res_status = StatHit;
          res_rmac   = found_mac_q;
        end else begin
          res_status = StatMiss;
          if (enable_q) begin
            res_fv    = 1'b1;
            res_fop   = FrameOpReq;
            res_fdst  = BroadcastMac;
            res_ftmac = BroadcastMac;
            res_ftip  = key_ip_q;
          end
        end
      end
      KIND_TICK: res_status = StatTick;
      KIND_NONE: res_status = status_q;
      default:   res_status = status_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o           <= res_status;
      frame_valid_o      <= res_fv;
      frame_opcode_o     <= res_fop;
      frame_dest_mac_o   <= res_fdst;
      frame_target_mac_o <= res_ftmac;
      frame_target_ip_o  <= res_ftip;
      resolved_mac_o     <= res_rmac;
    end
  end

  assign out_valid_o = out_valid_q;

  `ARPCR_ASSERT(a_cnt_range, cnt_q <= LastCnt, "scan counter past table end")
  `ARPCR_ASSERT_IMP(a_scan_done, state_q == ST_SCAN && state_d != ST_SCAN,
                    cnt_q == LastCnt, "scan left before last entry")
  `ARPCR_ASSERT_IMP(a_free_slot, state_q == ST_WRITE && !found_q && free_q,
                    !valid_q[free_idx_q], "learn would overwrite a live entry")
  `ARPCR_ASSERT_NXT(a_accept_go, in_valid_i && in_ready_o,
                    state_q == ST_SCAN || state_q == ST_FINISH, "accept did not start work")

endmodule
